>>> sv/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/brfo_pkg.sv
// Shared types and constants of the circular byte buffer.
// No dependencies; imported by the front end, the back end and the top level.
package brfo_pkg;

  localparam int BRFO_DEPTH     = 4096;
  localparam int BRFO_MAX_READ  = 64;
  localparam int BRFO_MAX_WRITE = 8;

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  localparam int CAP_W   = 13;
  localparam int FILL_W  = 13;
  localparam int CAP_MIN = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam int FLAG_OVERWRITE = 0;
  localparam int FLAG_NEWEST    = 1;
  localparam int FLAG_PEEK      = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] write_data;
    logic [6:0]  byte_count;
    logic [2:0]  mode_flags;
  } brfo_in_t;

  typedef struct packed {
    logic              status;
    logic [7:0]        data_byte;
    logic              has_data;
    logic              last_of_run;
    logic [FILL_W-1:0] fill_level;
  } brfo_out_t;

  typedef enum logic [1:0] {
    CMD_RESULT,
    CMD_WRITE,
    CMD_READ
  } brfo_cmd_kind_t;

  // One classified word handed from the front end to the back end.
  typedef struct packed {
    brfo_cmd_kind_t    kind;
    logic [6:0]        n;
    logic [63:0]       data;
    logic              status;
    logic [FILL_W-1:0] fill;
  } brfo_cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } brfo_bk_state_t;

endpackage

>>> sv/brfo_queue.sv
// Small first-in first-out queue of flip-flops with a level output.
// No dependencies; used for the command queue and the result queue.
module brfo_queue #(
  parameter int WIDTH   = 8,
  parameter int DEPTH_Q = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH_Q+1)-1:0] level
);

  localparam int PTR_W = (DEPTH_Q > 1) ? $clog2(DEPTH_Q) : 1;
  localparam int LVL_W = $clog2(DEPTH_Q+1);

  logic [WIDTH-1:0] slot_r [DEPTH_Q];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_wr, do_rd;

  assign full    = (level_r == LVL_W'(DEPTH_Q));
  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    level_nxt  = level_r;
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH_Q-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH_Q-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (do_rd && !do_wr) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> sv/brfo_front.sv
// Front end of the circular byte buffer: takes items, keeps the ring pointers
// and classifies each item into one command word. Depends on brfo_pkg.
module brfo_front import brfo_pkg::*; #(
  parameter int DEPTH     = BRFO_DEPTH,
  parameter int MAX_READ  = BRFO_MAX_READ,
  parameter int MAX_WRITE = BRFO_MAX_WRITE
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  brfo_in_t                 in_data,
  input  logic                     cmdq_full,
  input  logic                     cfg_wr_en,
  input  logic [CAP_W-1:0]         cfg_wr_data,
  output logic                     cmd_push,
  output brfo_cmd_t                cmd,
  output logic [$clog2(DEPTH)-1:0] cmd_addr,
  output logic [$clog2(DEPTH):0]   cap
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;

  logic [CAP_W-1:0] cap_raw_r;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [6:0]       wr_cnt7;
  logic [CNT_W-1:0] wr_cnt, room, excess, old_ow, old_w, cnt_w, tail;
  logic             wr_fits, wr_refused;
  logic [CNT_W-1:0] rd_cnt, start_new, start, old_rd;
  logic             rd_refused;
  logic             accept;

  // Values here stay below twice the capacity, so one subtract wraps them.
  function automatic logic [CNT_W-1:0] wrap(input logic [CNT_W-1:0] x,
                                            input logic [CNT_W-1:0] c);
    wrap = (x >= c) ? x - c : x;
  endfunction

  always_comb begin
    if (cap_raw_r < CAP_W'(CAP_MIN)) begin
      cap = CNT_W'(CAP_MIN);
    end else if (32'(cap_raw_r) > DEPTH) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = CNT_W'(cap_raw_r);
    end
  end

  assign accept   = push && !cmdq_full;
  assign cmd_push = accept;

  // Write path: make room by dropping the oldest bytes when overwrite is on.
  assign wr_cnt7    = (32'(in_data.byte_count) > MAX_WRITE) ? 7'(MAX_WRITE)
                                                            : in_data.byte_count;
  assign wr_cnt     = CNT_W'(wr_cnt7);
  assign room       = cap - count_r;
  assign wr_fits    = (wr_cnt <= room);
  assign excess     = wr_cnt - room;
  assign old_ow     = wrap(CNT_W'(oldest_r) + excess, cap);
  assign old_w      = wr_fits ? CNT_W'(oldest_r) : old_ow;
  assign cnt_w      = wr_fits ? count_r : count_r - excess;
  assign tail       = wrap(old_w + cnt_w, cap);
  assign wr_refused = !wr_fits && !in_data.mode_flags[FLAG_OVERWRITE];

  // Read path: the count is only used in arithmetic once it fits the fill level.
  assign rd_refused = (32'(in_data.byte_count) > MAX_READ) ||
                      (32'(in_data.byte_count) > 32'(count_r));
  assign rd_cnt     = CNT_W'(in_data.byte_count);
  assign start_new  = wrap(CNT_W'(oldest_r) + (count_r - rd_cnt), cap);
  assign start      = in_data.mode_flags[FLAG_NEWEST] ? start_new : CNT_W'(oldest_r);
  assign old_rd     = wrap(start + rd_cnt, cap);

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    cmd_addr   = '0;
    cmd.kind   = CMD_RESULT;
    cmd.n      = '0;
    cmd.data   = in_data.write_data;
    cmd.status = 1'b0;
    case (in_data.opcode)
      OP_WRITE: begin
        if (wr_refused) begin
          cmd.status = 1'b1;
        end else if (wr_cnt7 != '0) begin
          oldest_nxt = old_w[IDX_W-1:0];
          count_nxt  = cnt_w + wr_cnt;
          cmd.kind   = CMD_WRITE;
          cmd.n      = wr_cnt7;
          cmd_addr   = tail[IDX_W-1:0];
        end
      end
      OP_READ: begin
        if (rd_refused) begin
          cmd.status = 1'b1;
        end else if (in_data.byte_count != '0) begin
          cmd.kind = CMD_READ;
          cmd.n    = in_data.byte_count;
          cmd_addr = start[IDX_W-1:0];
          if (!in_data.mode_flags[FLAG_PEEK]) begin
            count_nxt = count_r - rd_cnt;
            if (!in_data.mode_flags[FLAG_NEWEST]) begin
              oldest_nxt = old_rd[IDX_W-1:0];
            end
          end
        end
      end
      OP_FLUSH: begin
        count_nxt = '0;
      end
      default: begin
        cmd.status = 1'b1;
      end
    endcase
    cmd.fill = FILL_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_raw_r <= CAP_RESET;
      oldest_r  <= '0;
      count_r   <= '0;
    end else if (cfg_wr_en) begin
      cap_raw_r <= cfg_wr_data;
      oldest_r  <= '0;
      count_r   <= '0;
    end else if (accept) begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/brfo_back.sv
// Back end of the circular byte buffer (needs brfo_pkg): holds the byte memory
// and steps through each command one byte per cycle while results have room.
module brfo_back import brfo_pkg::*; #(
  parameter int DEPTH = BRFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [$clog2(DEPTH):0]            cap,
  input  logic                              cmd_valid,
  input  brfo_cmd_t                         cmd_in,
  input  logic [$clog2(DEPTH)-1:0]          cmd_addr,
  output logic                              cmd_take,
  input  logic [$clog2(OUTQ_DEPTH+1)-1:0]   out_level,
  output logic                              res_push,
  output brfo_out_t                         res_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;

  brfo_bk_state_t   state_r, state_nxt;
  brfo_cmd_t        cmd_r;
  logic [IDX_W-1:0] addr_r, addr_inc;
  logic [6:0]       idx_r;
  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_r;
  logic             st_v_r;
  brfo_out_t        st_res_r, meta;

  logic is_last, credit, done, step, issue, mem_we, mem_re;
  logic [7:0] wbyte;

  assign is_last  = (idx_r + 7'd1 == cmd_r.n);
  // Room is reserved for the word already in the read-data stage.
  assign credit   = (32'(out_level) + 32'(st_v_r)) < OUTQ_DEPTH;
  assign addr_inc = (CNT_W'(addr_r) + CNT_W'(1) == cap) ? '0 : addr_r + IDX_W'(1);
  assign wbyte    = cmd_r.data[{idx_r[2:0], 3'b000} +: 8];
  assign cmd_take = ((state_r == BK_IDLE) || done) && cmd_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: state_nxt = cmd_valid ? BK_RUN : BK_IDLE;
      BK_RUN: begin
        if (done) begin
          state_nxt = cmd_valid ? BK_RUN : BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    done   = 1'b0;
    step   = 1'b0;
    issue  = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    if (state_r == BK_RUN) begin
      case (cmd_r.kind)
        CMD_RESULT: begin
          issue = credit;
          done  = credit;
        end
        CMD_WRITE: begin
          // The write result goes out together with the final byte.
          if (!is_last) begin
            mem_we = 1'b1;
            step   = 1'b1;
          end else if (credit) begin
            mem_we = 1'b1;
            issue  = 1'b1;
            done   = 1'b1;
          end
        end
        CMD_READ: begin
          if (credit) begin
            mem_re = 1'b1;
            issue  = 1'b1;
            step   = 1'b1;
            done   = is_last;
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  always_comb begin
    meta.status      = cmd_r.status;
    meta.data_byte   = '0;
    meta.has_data    = (cmd_r.kind == CMD_READ);
    meta.last_of_run = (cmd_r.kind != CMD_READ) || is_last;
    meta.fill_level  = cmd_r.fill;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      st_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_v_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r  <= cmd_in;
      addr_r <= cmd_addr;
      idx_r  <= '0;
    end else if (step) begin
      addr_r <= addr_inc;
      idx_r  <= idx_r + 7'd1;
    end
    if (issue) begin
      st_res_r <= meta;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wbyte;
    end
    if (mem_re) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_comb begin
    res_push = st_v_r;
    res_data = st_res_r;
    if (st_res_r.has_data) begin
      res_data.data_byte = rdata_r;
    end
  end

endmodule

>>> sv/byte_ring_fifo_overwrite_peek_top.sv
// Top level of the circular byte buffer with overwrite and peek.
// Depends on brfo_pkg, brfo_queue, brfo_front and brfo_back.

// Circular byte buffer of DEPTH bytes, of which cfg_wr_data sets how many are
// in use (8 to DEPTH); writing it empties the buffer. A write word stores up to
// MAX_WRITE bytes all or nothing, a read word returns up to MAX_READ bytes one
// per result, and a flush empties the buffer. The front end classifies a word in
// the cycle it is taken and queues it in a two-entry command queue, so several
// words can be taken back to back. The back end has a single-port byte memory
// and does one byte per cycle while the result queue has room: a write of N
// bytes gives one result with its final byte, a read of N bytes gives one
// result per byte, and any other word gives one result. Results pass through
// a registered read stage into a four-entry result queue. The byte memory has
// no reset; bytes are only read after they were written.
module byte_ring_fifo_overwrite_peek_top import brfo_pkg::*; #(
  parameter int DEPTH     = BRFO_DEPTH,
  parameter int MAX_READ  = BRFO_MAX_READ,
  parameter int MAX_WRITE = BRFO_MAX_WRITE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  brfo_in_t         in_data,
  output logic             empty,
  input  logic             pop,
  output brfo_out_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int CMDQ_W = $bits(brfo_cmd_t) + IDX_W;
  localparam int OUTQ_W = $bits(brfo_out_t);

  logic                            cmd_push, cmdq_full, cmdq_empty, cmd_take;
  brfo_cmd_t                       fe_cmd, q_cmd;
  logic [IDX_W-1:0]                fe_addr, q_addr;
  logic [CNT_W-1:0]                cap;
  logic [CMDQ_W-1:0]               q_word;
  logic                            res_push;
  brfo_out_t                       res_data;
  logic [$clog2(OUTQ_DEPTH+1)-1:0] out_level;
  logic [OUTQ_W-1:0]               out_word;

  assign full = cmdq_full;

  brfo_front #(
    .DEPTH     (DEPTH),
    .MAX_READ  (MAX_READ),
    .MAX_WRITE (MAX_WRITE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_data     (in_data),
    .cmdq_full   (cmdq_full),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_push    (cmd_push),
    .cmd         (fe_cmd),
    .cmd_addr    (fe_addr),
    .cap         (cap)
  );

  brfo_queue #(
    .WIDTH   (CMDQ_W),
    .DEPTH_Q (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data ({fe_cmd, fe_addr}),
    .rd_en   (cmd_take),
    .rd_data (q_word),
    .full    (cmdq_full),
    .empty   (cmdq_empty),
    .level   ()
  );

  assign {q_cmd, q_addr} = q_word;

  brfo_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap),
    .cmd_valid (!cmdq_empty),
    .cmd_in    (q_cmd),
    .cmd_addr  (q_addr),
    .cmd_take  (cmd_take),
    .out_level (out_level),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  brfo_queue #(
    .WIDTH   (OUTQ_W),
    .DEPTH_Q (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .rd_en   (pop),
    .rd_data (out_word),
    .full    (),
    .empty   (empty),
    .level   (out_level)
  );

  assign out_data = out_word;

endmodule

>>> sv/brfo_checker.sv
// Port-level checks of the circular byte buffer, bound to its top level.
// Depends on brfo_pkg and assert_macros.svh.
`include "assert_macros.svh"

module brfo_port_props import brfo_pkg::*; #(
  parameter int DEPTH = BRFO_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  input logic      empty,
  input logic      pop,
  input brfo_out_t out_data
);

  // A waiting word that is not taken stays in place.
  `ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(out_data))

  `ASSERT_IMPL(a_fill_bound, !empty, 32'(out_data.fill_level) <= DEPTH)

  // Data bytes only come from accepted reads.
  `ASSERT_IMPL(a_data_ok, !empty && out_data.has_data, !out_data.status)

  `ASSERT_IMPL(a_no_stray_byte, !empty && !out_data.has_data, out_data.data_byte == 8'd0)

  // A refused word never starts a run of bytes.
  `ASSERT_IMPL(a_refuse_single, !empty && out_data.status, out_data.last_of_run)

endmodule

bind byte_ring_fifo_overwrite_peek_top brfo_port_props #(.DEPTH(DEPTH)) u_brfo_port_props (.*);
